/* hdl/assert_macros.svh */
// Assertion macros shared by the transmitter modules.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* hdl/irfm_pkg.sv */
// Shared types, constants and helper functions for the IR follow-me transmitter.
// No dependencies; used by all irfm_* modules and the top level.
package irfm_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int BASE_BYTES  = 6;
  localparam int BYTE_POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_BYTE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_BYTE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_BYTE     = 3'd5;

  // reset values
  localparam logic [15:0] RST_UNIT_TICKS     = 16'd560;
  localparam logic [7:0]  RST_CARRIER_PERIOD = 8'd26;
  localparam logic [7:0]  RST_CARRIER_HIGH   = 8'd13;
  localparam logic [7:0]  RST_MODE_BYTE      = 8'h82;
  localparam logic [7:0]  RST_SETPOINT_BYTE  = 8'h48;
  localparam logic [7:0]  RST_TIMER_BYTE     = 8'h7F;

  localparam logic [7:0] HEADER_BYTE = 8'hA4;

  // segment phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HDR_MARK   = 3'd1;
  localparam logic [2:0] PH_HDR_SPACE  = 3'd2;
  localparam logic [2:0] PH_BIT_MARK   = 3'd3;
  localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
  localparam logic [2:0] PH_FOOT_MARK  = 3'd5;
  localparam logic [2:0] PH_FOOT_SPACE = 3'd6;

  // segment lengths in protocol units
  localparam logic [3:0] UNITS_HDR        = 4'd8;
  localparam logic [3:0] UNITS_SHORT      = 4'd1;
  localparam logic [3:0] UNITS_ONE_SPACE  = 4'd3;
  localparam logic [3:0] UNITS_FOOT_SPACE = 4'd10;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [7:0]  carrier_period;
    logic [7:0]  carrier_high;
    logic [7:0]  mode_byte;
    logic [7:0]  setpoint_byte;
    logic [7:0]  timer_byte;
  } cfg_t;

  typedef struct packed {
    logic ir_out;
    logic mark_active;
    logic busy_res;
    logic request_taken;
  } res_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

/* hdl/irfm_cfg_regs.sv */
// Configuration register file: timing, carrier and frame setting bytes.
// Depends on irfm_pkg.
module irfm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [irfm_pkg::CFG_IDX_W-1:0]   wr_idx_i,
  input  logic [irfm_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output irfm_pkg::cfg_t                   cfg_o
);

  irfm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_ticks     <= irfm_pkg::RST_UNIT_TICKS;
      cfg_q.carrier_period <= irfm_pkg::RST_CARRIER_PERIOD;
      cfg_q.carrier_high   <= irfm_pkg::RST_CARRIER_HIGH;
      cfg_q.mode_byte      <= irfm_pkg::RST_MODE_BYTE;
      cfg_q.setpoint_byte  <= irfm_pkg::RST_SETPOINT_BYTE;
      cfg_q.timer_byte     <= irfm_pkg::RST_TIMER_BYTE;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        irfm_pkg::REG_UNIT_TICKS:     cfg_q.unit_ticks     <= wr_data_i;
        irfm_pkg::REG_CARRIER_PERIOD: cfg_q.carrier_period <= wr_data_i[7:0];
        irfm_pkg::REG_CARRIER_HIGH:   cfg_q.carrier_high   <= wr_data_i[7:0];
        irfm_pkg::REG_MODE_BYTE:      cfg_q.mode_byte      <= wr_data_i[7:0];
        irfm_pkg::REG_SETPOINT_BYTE:  cfg_q.setpoint_byte  <= wr_data_i[7:0];
        irfm_pkg::REG_TIMER_BYTE:     cfg_q.timer_byte     <= wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/irfm_frame_build.sv */
// Frame assembly: header, setting bytes, temperature+1 and checksum.
// Depends on irfm_pkg (flip8, frame_t, cfg_t).
module irfm_frame_build (
  input  irfm_pkg::cfg_t    cfg_i,
  input  logic [6:0]        temperature_i,
  output irfm_pkg::frame_t  frame_o
);

  logic [irfm_pkg::BASE_BYTES-1:0][7:0] base;
  logic [7:0] sum;

  always_comb begin
    base[0] = irfm_pkg::HEADER_BYTE;
    base[1] = cfg_i.mode_byte;
    base[2] = cfg_i.setpoint_byte;
    base[3] = cfg_i.timer_byte;
    base[4] = {1'b0, temperature_i} + 8'd1;
    // checksum over bit-reversed bytes, then reversed back
    sum = irfm_pkg::flip8(base[0]) + irfm_pkg::flip8(base[1]) +
          irfm_pkg::flip8(base[2]) + irfm_pkg::flip8(base[3]) +
          irfm_pkg::flip8(base[4]);
    base[5] = irfm_pkg::flip8(8'd0 - sum);
  end

  for (genvar g = 0; g < irfm_pkg::FRAME_BYTES; g++) begin : g_byte
    if (g < irfm_pkg::BASE_BYTES) begin : g_used
      assign frame_o[g] = base[g];
    end else begin : g_pad
      assign frame_o[g] = 8'd0;
    end
  end

endmodule

/* hdl/irfm_tx_engine.sv */
// Transmit sequencer: frame store, segment state, unit and carrier timers.
// Depends on irfm_pkg; result is registered downstream in irfm_out_buf.
`include "assert_macros.svh"
module irfm_tx_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              kind_i,
  input  irfm_pkg::frame_t  frame_i,
  input  irfm_pkg::cfg_t    cfg_i,
  output irfm_pkg::res_t    res_o
);

  localparam int BPW = irfm_pkg::BYTE_POS_W;
  localparam int BIW = irfm_pkg::BYTE_IDX_W;

  irfm_pkg::frame_t frame_q;
  logic             frame_we;

  logic [2:0]     phase_q, phase_d;
  logic           inverted_q, inverted_d;
  logic [BPW-1:0] byte_pos_q, byte_pos_d;
  logic [2:0]     bit_pos_q, bit_pos_d;
  logic [3:0]     units_q, units_d;
  logic [15:0]    unit_cnt_q, unit_cnt_d;
  logic [7:0]     car_cnt_q, car_cnt_d;

  logic           is_mark;
  logic [7:0]     cur_byte;
  logic           cur_bit;
  logic [15:0]    unit_len;
  logic [16:0]    unit_sum;
  logic [8:0]     car_sum;
  logic [3:0]     units_dec;
  logic [BPW-1:0] byte_pos_inc;

  always_comb begin
    is_mark = (phase_q == irfm_pkg::PH_HDR_MARK) || (phase_q == irfm_pkg::PH_BIT_MARK) ||
              (phase_q == irfm_pkg::PH_FOOT_MARK);
    cur_byte = (byte_pos_q < BPW'(irfm_pkg::FRAME_BYTES)) ? frame_q[byte_pos_q[BIW-1:0]]
                                                           : 8'd0;
    cur_bit  = cur_byte[3'd7 - bit_pos_q] ^ inverted_q;
    unit_len = (cfg_i.unit_ticks == 16'd0) ? 16'd1 : cfg_i.unit_ticks;
    unit_sum = {1'b0, unit_cnt_q} + 17'd1;
    car_sum  = {1'b0, car_cnt_q} + 9'd1;
    units_dec = (units_q == 4'd0) ? 4'd0 : units_q - 4'd1;
    byte_pos_inc = byte_pos_q + BPW'(1);
  end

  always_comb begin
    phase_d    = phase_q;
    inverted_d = inverted_q;
    byte_pos_d = byte_pos_q;
    bit_pos_d  = bit_pos_q;
    units_d    = units_q;
    unit_cnt_d = unit_cnt_q;
    car_cnt_d  = car_cnt_q;
    frame_we   = 1'b0;
    res_o      = '0;

    if (kind_i) begin
      if (phase_q == irfm_pkg::PH_IDLE) begin
        frame_we   = fire_i;
        inverted_d = 1'b0;
        byte_pos_d = '0;
        bit_pos_d  = 3'd0;
        unit_cnt_d = 16'd0;
        car_cnt_d  = 8'd0;
        phase_d    = irfm_pkg::PH_HDR_MARK;
        units_d    = irfm_pkg::UNITS_HDR;
        res_o.request_taken = 1'b1;
      end
      res_o.busy_res = (phase_d != irfm_pkg::PH_IDLE);
    end else if (phase_q != irfm_pkg::PH_IDLE) begin
      res_o.busy_res    = 1'b1;
      res_o.mark_active = is_mark;
      res_o.ir_out      = is_mark && (car_cnt_q < cfg_i.carrier_high);
      car_cnt_d = (car_sum >= {1'b0, cfg_i.carrier_period}) ? 8'd0 : car_sum[7:0];
      if (unit_sum >= {1'b0, unit_len}) begin
        unit_cnt_d = 16'd0;
        units_d    = units_dec;
        if (units_dec == 4'd0) begin
          unique case (phase_q)
            irfm_pkg::PH_HDR_MARK: begin
              phase_d = irfm_pkg::PH_HDR_SPACE;
              units_d = irfm_pkg::UNITS_HDR;
            end
            irfm_pkg::PH_HDR_SPACE: begin
              phase_d = irfm_pkg::PH_BIT_MARK;
              units_d = irfm_pkg::UNITS_SHORT;
            end
            irfm_pkg::PH_BIT_MARK: begin
              phase_d = irfm_pkg::PH_BIT_SPACE;
              units_d = cur_bit ? irfm_pkg::UNITS_ONE_SPACE : irfm_pkg::UNITS_SHORT;
            end
            irfm_pkg::PH_BIT_SPACE: begin
              if (bit_pos_q == 3'd7) begin
                bit_pos_d  = 3'd0;
                byte_pos_d = byte_pos_inc;
              end else begin
                bit_pos_d = bit_pos_q + 3'd1;
              end
              phase_d = (byte_pos_d >= BPW'(irfm_pkg::FRAME_BYTES)) ? irfm_pkg::PH_FOOT_MARK
                                                                     : irfm_pkg::PH_BIT_MARK;
              units_d = irfm_pkg::UNITS_SHORT;
            end
            irfm_pkg::PH_FOOT_MARK: begin
              phase_d = irfm_pkg::PH_FOOT_SPACE;
              units_d = irfm_pkg::UNITS_FOOT_SPACE;
            end
            default: begin
              if (phase_q == irfm_pkg::PH_FOOT_SPACE && !inverted_q) begin
                // second pass, all bits inverted
                inverted_d = 1'b1;
                byte_pos_d = '0;
                bit_pos_d  = 3'd0;
                phase_d    = irfm_pkg::PH_HDR_MARK;
                units_d    = irfm_pkg::UNITS_HDR;
              end else begin
                phase_d    = irfm_pkg::PH_IDLE;
                inverted_d = 1'b0;
                byte_pos_d = '0;
                bit_pos_d  = 3'd0;
                units_d    = 4'd0;
                unit_cnt_d = 16'd0;
                car_cnt_d  = 8'd0;
              end
            end
          endcase
        end
      end else begin
        unit_cnt_d = unit_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= irfm_pkg::PH_IDLE;
      inverted_q <= 1'b0;
      byte_pos_q <= '0;
      bit_pos_q  <= 3'd0;
      units_q    <= 4'd0;
      unit_cnt_q <= 16'd0;
      car_cnt_q  <= 8'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      inverted_q <= inverted_d;
      byte_pos_q <= byte_pos_d;
      bit_pos_q  <= bit_pos_d;
      units_q    <= units_d;
      unit_cnt_q <= unit_cnt_d;
      car_cnt_q  <= car_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q <= frame_i;
    end
  end

  `ASSERT_PROP(a_start_hdr, clk_i, rst_ni,
    (fire_i && res_o.request_taken) |=>
      (phase_q == irfm_pkg::PH_HDR_MARK && units_q == irfm_pkg::UNITS_HDR))
  `ASSERT_PROP(a_idle_clean, clk_i, rst_ni,
    (phase_q == irfm_pkg::PH_IDLE) |-> (units_q == 4'd0 && !inverted_q && byte_pos_q == '0))
  `ASSERT_PROP(a_byte_pos_range, clk_i, rst_ni,
    byte_pos_q <= BPW'(irfm_pkg::FRAME_BYTES))

endmodule

/* hdl/irfm_out_buf.sv */
// Result register with a skid stage so input keeps flowing under output stall until the skid is full.
// Depends on irfm_pkg (res_t).
`include "assert_macros.svh"
module irfm_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  irfm_pkg::res_t  res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output irfm_pkg::res_t  res_o
);

  logic           out_valid_q;
  logic           skid_valid_q;
  irfm_pkg::res_t out_q;
  irfm_pkg::res_t skid_q;
  logic           out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `ASSERT_PROP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, push_i && skid_valid_q)

endmodule

/* hdl/ir_follow_me_frame_transmitter.sv */
// IR follow-me frame transmitter: one result per item, registered in irfm_out_buf.
// One item per clock unless stalled; result register plus a one-entry skid stage
// let input flow while a result waits, input stalls only when the skid is full.
// Reset clears sequencer state and loads configuration defaults; frame store is
// not reset and is loaded when a send request is taken.
module ir_follow_me_frame_transmitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [6:0]                       temperature_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ir_out_o,
  output logic                             mark_active_o,
  output logic                             busy_res_o,
  output logic                             request_taken_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [irfm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [irfm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  irfm_pkg::cfg_t   cfg;
  irfm_pkg::frame_t frame;
  irfm_pkg::res_t   res;
  irfm_pkg::res_t   res_out;
  logic             full;
  logic             fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign fire        = in_valid_i && !full;

  irfm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  irfm_frame_build u_build (
    .cfg_i         (cfg),
    .temperature_i (temperature_i),
    .frame_o       (frame)
  );

  irfm_tx_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .kind_i  (kind_i),
    .frame_i (frame),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  irfm_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign ir_out_o        = res_out.ir_out;
  assign mark_active_o   = res_out.mark_active;
  assign busy_res_o      = res_out.busy_res;
  assign request_taken_o = res_out.request_taken;

endmodule
